>>> hw/rtl/tcf_pkg.sv
// tcf_pkg: shared constants and types for the text filter.
// Character codes, register indexes and the command word that the front
// hands to the back through the queue. No dependencies.
`timescale 1ns / 1ps

package tcf_pkg;

    // Character codes
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_QMARK    = 8'd63;
    localparam logic [7:0] CH_I        = 8'd73;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CH_CTRL_TOP = 8'd32;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

    // Per-byte command: which prefix words to emit, then the final byte
    typedef struct packed {
        logic       has_num;
        logic       has_dollar;
        logic       has_caret;
        logic [7:0] ch;
    } t_cmd;

    localparam int unsigned CMD_W = $bits(t_cmd);

endpackage

>>> hw/rtl/tcf_front.sv
// tcf_front: accepts input bytes, holds configuration and line state,
// and classifies each byte into a command for the back end.
// Depends on tcf_pkg.
`timescale 1ns / 1ps

module tcf_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [tcf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_valid,
    input  logic [7:0]                    i_byte,
    input  logic                          i_room,
    output logic                          o_ready,
    output logic                          o_push,
    output tcf_pkg::t_cmd                 o_cmd,
    output logic [4*NUMBER_DIGITS-1:0]    o_bcd
);

    localparam int BCD_W = 4 * NUMBER_DIGITS;

    logic r_number_all, r_number_nonblank, r_squeeze_blank;
    logic r_show_ends, r_show_tabs, r_show_nonprinting;
    logic r_after_nl, n_after_nl;
    logic [1:0] r_blank_run, n_blank_run;
    logic [BCD_W-1:0] r_bcd, n_bcd;

    logic             accept, nl, sq_hit, drop, do_num, caret;
    logic [1:0]       blank_inc;
    logic [7:0]       ch;
    logic [BCD_W-1:0] bcd_inc;
    logic             carry;
    logic [3:0]       dig;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign nl      = (i_byte == tcf_pkg::CH_NL);
    assign sq_hit  = r_squeeze_blank && r_after_nl && nl;
    assign blank_inc = (r_blank_run == 2'd3) ? 2'd3 : r_blank_run + 2'd1;
    assign drop    = sq_hit && (blank_inc > 2'd1);
    assign do_num  = r_after_nl &&
                     ((r_number_all && !r_number_nonblank) || (r_number_nonblank && !nl));

    // Caret notation for tab and control bytes
    always_comb begin
        caret = 1'b0;
        ch    = i_byte;
        if (i_byte == tcf_pkg::CH_TAB && r_show_tabs) begin
            caret = 1'b1;
            ch    = tcf_pkg::CH_I;
        end else if (r_show_nonprinting && i_byte != tcf_pkg::CH_TAB && !nl) begin
            if (i_byte == tcf_pkg::CH_DEL) begin
                caret = 1'b1;
                ch    = tcf_pkg::CH_QMARK;
            end else if (i_byte < tcf_pkg::CH_CTRL_TOP) begin
                caret = 1'b1;
                ch    = i_byte + tcf_pkg::CTRL_OFFSET;
            end
        end
    end

    // BCD count-up, wraps to zero after all nines
    always_comb begin
        carry   = 1'b1;
        bcd_inc = '0;
        dig     = '0;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            dig = r_bcd[4*i +: 4];
            if (carry) begin
                if (dig >= 4'd9) begin
                    dig   = 4'd0;
                    carry = 1'b1;
                end else begin
                    dig   = dig + 4'd1;
                    carry = 1'b0;
                end
            end
            bcd_inc[4*i +: 4] = dig;
        end
    end

    always_comb begin
        n_after_nl  = r_after_nl;
        n_blank_run = r_blank_run;
        n_bcd       = r_bcd;
        if (accept) begin
            if (sq_hit) begin
                n_blank_run = blank_inc;
            end
            if (!drop) begin
                if (do_num) begin
                    n_bcd = bcd_inc;
                end
                if (r_after_nl && !nl) begin
                    n_blank_run = 2'd0;
                end
                n_after_nl = nl;
            end
        end
    end

    assign o_push            = accept && !drop;
    assign o_cmd.has_num     = do_num;
    assign o_cmd.has_dollar  = r_show_ends && nl;
    assign o_cmd.has_caret   = caret;
    assign o_cmd.ch          = ch;
    assign o_bcd             = r_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_all       <= 1'b0;
            r_number_nonblank  <= 1'b0;
            r_squeeze_blank    <= 1'b0;
            r_show_ends        <= 1'b0;
            r_show_tabs        <= 1'b0;
            r_show_nonprinting <= 1'b0;
            r_after_nl         <= 1'b1;
            r_blank_run        <= 2'd0;
            r_bcd              <= BCD_W'(1);
        end else begin
            r_after_nl  <= n_after_nl;
            r_blank_run <= n_blank_run;
            r_bcd       <= n_bcd;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tcf_pkg::REG_NUMBER_ALL:       r_number_all       <= i_cfg_data;
                    tcf_pkg::REG_NUMBER_NONBLANK:  r_number_nonblank  <= i_cfg_data;
                    tcf_pkg::REG_SQUEEZE_BLANK:    r_squeeze_blank    <= i_cfg_data;
                    tcf_pkg::REG_SHOW_ENDS:        r_show_ends        <= i_cfg_data;
                    tcf_pkg::REG_SHOW_TABS:        r_show_tabs        <= i_cfg_data;
                    tcf_pkg::REG_SHOW_NONPRINTING: r_show_nonprinting <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/tcf_queue.sv
// tcf_queue: short register queue between the front and the back end.
// Push and pop may happen in the same cycle. No package dependency.
`timescale 1ns / 1ps

module tcf_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_wdata,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_rdata,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/tcf_back.sv
// tcf_back: expands one command into its output words, one word a cycle while the output
// is not stalled, through a registered output stage. Depends on tcf_pkg.
`timescale 1ns / 1ps

module tcf_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  tcf_pkg::t_cmd              i_cmd,
    input  logic [4*NUMBER_DIGITS-1:0] i_bcd,
    output logic                       o_pop,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tlast
);

    localparam int STEP_W = $clog2(NUMBER_DIGITS + 4);
    localparam logic [STEP_W-1:0] S_FIRST = '0;
    localparam logic [STEP_W-1:0] S_TAB   = STEP_W'(NUMBER_DIGITS);
    localparam logic [STEP_W-1:0] S_END   = STEP_W'(NUMBER_DIGITS + 1);
    localparam logic [STEP_W-1:0] S_CARET = STEP_W'(NUMBER_DIGITS + 2);
    localparam logic [STEP_W-1:0] S_CHAR  = STEP_W'(NUMBER_DIGITS + 3);

    logic              r_valid, r_last, r_started;
    logic [7:0]        r_byte;
    logic [STEP_W-1:0] r_step;

    logic [STEP_W-1:0] start_step, step, next_step;
    logic [7:0]        dch [NUMBER_DIGITS];
    logic [7:0]        word;
    logic              seen_nz, load, fire, is_last;
    logic [3:0]        d;

    assign start_step = i_cmd.has_num    ? S_FIRST :
                        i_cmd.has_dollar ? S_END   :
                        i_cmd.has_caret  ? S_CARET : S_CHAR;
    assign step = r_started ? r_step : start_step;

    // Digit characters, leading zeros blanked, ones column always shown
    always_comb begin
        seen_nz = 1'b0;
        d       = '0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            d = i_bcd[4*i +: 4];
            if (d > 4'd9) begin
                d = 4'd9;
            end
            if (d != 4'd0 || i == 0) begin
                seen_nz = 1'b1;
            end
            dch[i] = seen_nz ? (tcf_pkg::CH_ZERO + {4'b0000, d}) : tcf_pkg::CH_SPACE;
        end
    end

    always_comb begin
        word = i_cmd.ch;
        priority if (step < S_TAB) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                if (step == STEP_W'(NUMBER_DIGITS - 1 - i)) begin
                    word = dch[i];
                end
            end
        end else if (step == S_TAB) begin
            word = tcf_pkg::CH_TAB;
        end else if (step == S_END) begin
            word = tcf_pkg::CH_DOLLAR;
        end else if (step == S_CARET) begin
            word = tcf_pkg::CH_CARET;
        end else begin
            word = i_cmd.ch;
        end
    end

    always_comb begin
        priority if (step < S_TAB) begin
            next_step = step + STEP_W'(1);
        end else if (step == S_TAB) begin
            next_step = i_cmd.has_dollar ? S_END : (i_cmd.has_caret ? S_CARET : S_CHAR);
        end else if (step == S_END) begin
            next_step = i_cmd.has_caret ? S_CARET : S_CHAR;
        end else begin
            next_step = S_CHAR;
        end
    end

    assign is_last = (step == S_CHAR);
    assign load    = !r_valid || i_m_tready;
    assign fire    = load && !i_empty;
    assign o_pop   = fire && is_last;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= word;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
            r_step    <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            if (fire) begin
                r_started <= !is_last;
                r_step    <= next_step;
            end
        end
    end

endmodule

>>> hw/rtl/text_cat_filter.sv
// text_cat_filter: line numbering and visible-character filter, top level.
// Path: an accepted byte is written into the command queue, and its first word is then
// loaded from the queue into the output register.
// Throughput: one word per cycle at the output register while i_m_tready holds; a byte costs 1 to
// NUMBER_DIGITS+3 words, so input runs at one byte a cycle until multi-word commands or output stalls fill the queue.
// Reset: synchronous, active low; clears options, sets line count to 1, empties the queue.
`timescale 1ns / 1ps

module text_cat_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] in_byte
    // Output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // [7:0] out_byte
    output logic                          o_m_tlast,   // last_of_run
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data
);

    // Two command slots let the front keep taking bytes while the back
    // is still expanding a line-number prefix.
    localparam int QDEPTH = 2;
    localparam int BCD_W  = 4 * NUMBER_DIGITS;
    localparam int QW     = tcf_pkg::CMD_W + BCD_W;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic              q_push, q_pop, q_full, q_empty;
    logic [CNT_W-1:0]  q_count;
    logic [QW-1:0]     q_wdata, q_rdata;
    tcf_pkg::t_cmd     front_cmd, back_cmd;
    logic [BCD_W-1:0]  front_bcd, back_bcd;

    // Configuration writes go straight into registers, always take them
    assign o_cfg_ready = 1'b1;

    // Front: classify the byte, advance line state, drop squeezed newlines
    tcf_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .i_room      (!q_full),
        .o_ready     (o_s_tready),
        .o_push      (q_push),
        .o_cmd       (front_cmd),
        .o_bcd       (front_bcd)
    );

    // Pack the command with a snapshot of the line number it prints
    assign q_wdata  = {front_bcd, front_cmd};
    assign back_cmd = q_rdata[tcf_pkg::CMD_W-1:0];
    assign back_bcd = q_rdata[QW-1:tcf_pkg::CMD_W];

    tcf_queue #(
        .W     (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // Back: walk digits, tab, dollar, caret, byte; pop on the final word
    tcf_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cmd      (back_cmd),
        .i_bcd      (back_bcd),
        .o_pop      (q_pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Front never pushes into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Back never pops an empty queue
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // Queue occupancy stays within its slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(QDEPTH))
        else $error("queue count out of range");

    // A command slot is popped as its final word loads into the output register
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_m_tvalid && o_m_tlast)
        else $error("pop without final word loaded");

endmodule
